>>> hdl/prg_pkg.sv
package prg_pkg;

  localparam int RES_X = 1920;
  localparam int RES_Y = 1080;

  // reciprocal scale, 2^31 / res, floor
  localparam int RECIP_SH = 31;
  localparam logic [31:0] RECIP_X = 32'((64'd1 << RECIP_SH) / RES_X);
  localparam logic [31:0] RECIP_Y = 32'((64'd1 << RECIP_SH) / RES_Y);

  localparam int SQRT_STAGES = 32;
  localparam int DIV_STAGES  = 64;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEWER_DIST = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PROJ_POS_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PROJ_POS_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PROJ_POS_Z  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DIFF_MODE   = 3'd6;

  localparam logic [1:0] MODE_LINEAR  = 2'd0;
  localparam logic [1:0] MODE_CONICAL = 2'd1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZDIV = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  typedef struct packed {
    logic [30:0]        half_width;
    logic [30:0]        half_height;
    logic signed [31:0] viewer_distance;
    logic signed [31:0] proj_pos_x;
    logic signed [31:0] proj_pos_y;
    logic signed [31:0] proj_pos_z;
    logic [1:0]         diffuser_mode;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] x0;
    logic signed [31:0] y0;
    logic signed [31:0] dx;
    logic signed [31:0] dz;
    logic               sat;
    logic               zdiv;
    logic               neg;
  } side_t;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic [1:0]         status;
  } res_t;

  // {saturated, value}
  function automatic logic [32:0] sat32(input logic signed [65:0] v);
    logic [32:0] r;
    if (v > $signed({34'd0, 32'h7fff_ffff})) begin
      r = {1'b1, 32'h7fff_ffff};
    end else if (v < $signed({{34{1'b1}}, 32'h8000_0000})) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

>>> hdl/prg_in_if.sv
interface prg_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_x;
  logic [15:0] pixel_y;
  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

>>> hdl/prg_out_if.sv
interface prg_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] origin_x;
  logic signed [31:0] dir_x;
  logic signed [31:0] dir_y;
  logic signed [31:0] dir_z;
  logic [1:0]         status;
  modport source (output valid, output origin_x, output dir_x, output dir_y, output dir_z,
                  output status, input ready);
  modport sink (input valid, input origin_x, input dir_x, input dir_y, input dir_z,
                input status, output ready);
endinterface

>>> hdl/prg_front.sv
module prg_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  prg_pkg::cfg_t     cfg,
  input  logic              in_vld,
  input  logic [15:0]       px,
  input  logic [15:0]       py,
  output logic              out_vld,
  output prg_pkg::side_t    out_side,
  output logic [63:0]       sum_a,
  output logic [63:0]       sum_b
);

  logic [28:0] nx_nxt, ny_nxt;
  logic [60:0] prodx, prody;
  logic [28:0] nx1_r, ny1_r, qx1_r, qy1_r;
  logic        v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r;

  logic [28:0] rx, ry, qx, qy;
  logic signed [30:0] lx2_nxt, ly2_nxt, lx2_r, ly2_r;

  logic signed [62:0] px3_nxt, py3_nxt, px3_r, py3_r;

  logic [32:0] sx4, sy4;
  logic signed [31:0] x04_r, y04_r;
  logic sat4_r;

  logic [32:0] sdx, sdy, sdz;
  prg_pkg::side_t side5_nxt, side5_r, side6_r, side7_r;
  logic signed [31:0] dy5_r;

  logic signed [63:0] qdy, qdz, qy0, qz0;
  logic [62:0] qdy6_r, qdz6_r, qy06_r, qz06_r;
  logic [63:0] sa7_r, sb7_r;

  assign nx_nxt = {px, 13'd0};
  assign ny_nxt = {py, 13'd0};
  assign prodx  = {32'd0, nx_nxt} * {29'd0, prg_pkg::RECIP_X};
  assign prody  = {32'd0, ny_nxt} * {29'd0, prg_pkg::RECIP_Y};

  // estimate is exact or one short
  assign rx = nx1_r - (qx1_r * 29'(prg_pkg::RES_X));
  assign ry = ny1_r - (qy1_r * 29'(prg_pkg::RES_Y));
  assign qx = qx1_r + 29'(rx >= 29'(prg_pkg::RES_X));
  assign qy = qy1_r + 29'(ry >= 29'(prg_pkg::RES_Y));
  assign lx2_nxt = $signed({2'b00, qx}) - 31'sd65536;
  assign ly2_nxt = 31'sd65536 - $signed({2'b00, qy});

  assign px3_nxt = 63'(lx2_r) * 63'($signed({1'b0, cfg.half_width}));
  assign py3_nxt = 63'(ly2_r) * 63'($signed({1'b0, cfg.half_height}));

  assign sx4 = prg_pkg::sat32(66'(px3_r >>> 16));
  assign sy4 = prg_pkg::sat32(66'(py3_r >>> 16));

  assign sdx = prg_pkg::sat32(66'(x04_r) - 66'(cfg.proj_pos_x));
  assign sdy = prg_pkg::sat32(66'(y04_r) - 66'(cfg.proj_pos_y));
  assign sdz = prg_pkg::sat32(66'(cfg.viewer_distance) - 66'(cfg.proj_pos_z));

  always_comb begin
    side5_nxt      = '0;
    side5_nxt.x0   = x04_r;
    side5_nxt.y0   = y04_r;
    side5_nxt.dx   = sdx[31:0];
    side5_nxt.dz   = sdz[31:0];
    side5_nxt.sat  = sat4_r | sdx[32] | sdy[32] | sdz[32];
  end

  assign qdy = 64'(dy5_r) * 64'(dy5_r);
  assign qdz = 64'(side5_r.dz) * 64'(side5_r.dz);
  assign qy0 = 64'(side5_r.y0) * 64'(side5_r.y0);
  assign qz0 = 64'(cfg.viewer_distance) * 64'(cfg.viewer_distance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx1_r   <= nx_nxt;
      ny1_r   <= ny_nxt;
      qx1_r   <= prodx[59:31];
      qy1_r   <= prody[59:31];
      lx2_r   <= lx2_nxt;
      ly2_r   <= ly2_nxt;
      px3_r   <= px3_nxt;
      py3_r   <= py3_nxt;
      x04_r   <= sx4[31:0];
      y04_r   <= sy4[31:0];
      sat4_r  <= sx4[32] | sy4[32];
      side5_r <= side5_nxt;
      dy5_r   <= sdy[31:0];
      qdy6_r  <= qdy[62:0];
      qdz6_r  <= qdz[62:0];
      qy06_r  <= qy0[62:0];
      qz06_r  <= qz0[62:0];
      side6_r <= side5_r;
      sa7_r   <= {1'b0, qdy6_r} + {1'b0, qdz6_r};
      sb7_r   <= {1'b0, qy06_r} + {1'b0, qz06_r};
      side7_r <= side6_r;
    end
  end

  assign out_vld  = v7_r;
  assign out_side = side7_r;
  assign sum_a    = sa7_r;
  assign sum_b    = sb7_r;

endmodule

>>> hdl/prg_sqrt.sv
module prg_sqrt (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  prg_pkg::side_t    in_side,
  input  logic [63:0]       in_a,
  input  logic [63:0]       in_b,
  output logic              out_vld,
  output prg_pkg::side_t    out_side,
  output logic [31:0]       root_a,
  output logic [31:0]       root_b
);

  localparam int N = prg_pkg::SQRT_STAGES;

  // one result bit per stage: {remainder, root}
  function automatic logic [65:0] root_step(input logic [33:0] rem, input logic [31:0] root,
                                            input logic [1:0] pair);
    logic [33:0] rsh;
    logic [33:0] trial;
    logic [65:0] r;
    rsh   = {rem[31:0], pair};
    trial = {root, 2'b01};
    if (rsh >= trial) begin
      r = {rsh - trial, root[30:0], 1'b1};
    end else begin
      r = {rsh, root[30:0], 1'b0};
    end
    return r;
  endfunction

  logic [63:0] va_in [N], vb_in [N], va_r [N], vb_r [N];
  logic [33:0] ra_in [N], rb_in [N], ra_r [N], rb_r [N];
  logic [31:0] ta_in [N], tb_in [N], ta_r [N], tb_r [N];
  logic        vl_in [N], vl_r [N];
  prg_pkg::side_t sd_in [N], sd_r [N];

  for (genvar g = 0; g < N; g++) begin : g_stage
    logic [65:0] sa_nxt, sb_nxt;
    if (g == 0) begin : g_first
      assign va_in[g] = in_a;
      assign vb_in[g] = in_b;
      assign ra_in[g] = '0;
      assign rb_in[g] = '0;
      assign ta_in[g] = '0;
      assign tb_in[g] = '0;
      assign vl_in[g] = in_vld;
      assign sd_in[g] = in_side;
    end else begin : g_next
      assign va_in[g] = va_r[g-1];
      assign vb_in[g] = vb_r[g-1];
      assign ra_in[g] = ra_r[g-1];
      assign rb_in[g] = rb_r[g-1];
      assign ta_in[g] = ta_r[g-1];
      assign tb_in[g] = tb_r[g-1];
      assign vl_in[g] = vl_r[g-1];
      assign sd_in[g] = sd_r[g-1];
    end

    assign sa_nxt = root_step(ra_in[g], ta_in[g], va_in[g][63:62]);
    assign sb_nxt = root_step(rb_in[g], tb_in[g], vb_in[g][63:62]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vl_r[g] <= 1'b0;
      end else if (en) begin
        vl_r[g] <= vl_in[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        va_r[g] <= {va_in[g][61:0], 2'b00};
        vb_r[g] <= {vb_in[g][61:0], 2'b00};
        ra_r[g] <= sa_nxt[65:32];
        rb_r[g] <= sb_nxt[65:32];
        ta_r[g] <= sa_nxt[31:0];
        tb_r[g] <= sb_nxt[31:0];
        sd_r[g] <= sd_in[g];
      end
    end
  end

  assign out_vld  = vl_r[N-1];
  assign out_side = sd_r[N-1];
  assign root_a   = ta_r[N-1];
  assign root_b   = tb_r[N-1];

endmodule

>>> hdl/prg_div.sv
module prg_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  prg_pkg::side_t    in_side,
  input  logic [63:0]       in_num,
  input  logic [31:0]       in_den,
  output logic              out_vld,
  output prg_pkg::side_t    out_side,
  output logic [63:0]       quot
);

  localparam int N = prg_pkg::DIV_STAGES;

  // dividend shifts out at the top while quotient bits shift in at the bottom
  logic [63:0] nq_in [N], nq_r [N];
  logic [31:0] rm_in [N], rm_r [N];
  logic [31:0] dn_in [N], dn_r [N];
  logic        vl_in [N], vl_r [N];
  prg_pkg::side_t sd_in [N], sd_r [N];

  for (genvar g = 0; g < N; g++) begin : g_stage
    logic [32:0] rsh;
    logic        take;
    if (g == 0) begin : g_first
      assign nq_in[g] = in_num;
      assign rm_in[g] = '0;
      assign dn_in[g] = in_den;
      assign vl_in[g] = in_vld;
      assign sd_in[g] = in_side;
    end else begin : g_next
      assign nq_in[g] = nq_r[g-1];
      assign rm_in[g] = rm_r[g-1];
      assign dn_in[g] = dn_r[g-1];
      assign vl_in[g] = vl_r[g-1];
      assign sd_in[g] = sd_r[g-1];
    end

    assign rsh  = {rm_in[g], nq_in[g][63]};
    assign take = rsh >= {1'b0, dn_in[g]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vl_r[g] <= 1'b0;
      end else if (en) begin
        vl_r[g] <= vl_in[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nq_r[g] <= {nq_in[g][62:0], take};
        rm_r[g] <= take ? 32'(rsh - {1'b0, dn_in[g]}) : rsh[31:0];
        dn_r[g] <= dn_in[g];
        sd_r[g] <= sd_in[g];
      end
    end
  end

  assign out_vld  = vl_r[N-1];
  assign out_side = sd_r[N-1];
  assign quot     = nq_r[N-1];

endmodule

>>> hdl/prg_back.sv
module prg_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  prg_pkg::cfg_t     cfg,
  input  logic              in_vld,
  input  prg_pkg::side_t    in_side,
  input  logic [63:0]       quot,
  output logic              out_vld,
  output prg_pkg::res_t     out_res
);

  logic [63:0] qs;
  logic        sub;
  logic        active;
  logic signed [65:0] xsum;
  logic [32:0] xs;
  logic signed [31:0] x1_nxt, x1_r, x01_r, y01_r;
  logic sat1_nxt, sat1_r, zdiv1_r, v1_r, v2_r;
  logic [32:0] ds;
  prg_pkg::res_t res_nxt, res_r;

  assign active = (cfg.diffuser_mode == prg_pkg::MODE_LINEAR) ||
                  (cfg.diffuser_mode == prg_pkg::MODE_CONICAL);
  assign qs  = in_side.zdiv ? 64'd0 : quot;
  // linear takes x0 - q, conical x0 + q; a set neg flag swaps the two
  assign sub = (cfg.diffuser_mode == prg_pkg::MODE_LINEAR) ^ in_side.neg;
  assign xsum = sub ? (66'(in_side.x0) - $signed({2'b00, qs}))
                    : (66'(in_side.x0) + $signed({2'b00, qs}));
  assign xs = prg_pkg::sat32(xsum);
  assign x1_nxt   = active ? $signed(xs[31:0]) : 32'sd0;
  assign sat1_nxt = in_side.sat | (active & xs[32]);

  assign ds = prg_pkg::sat32(66'(x01_r) - 66'(x1_r));

  always_comb begin
    res_nxt          = '0;
    res_nxt.origin_x = x1_r;
    res_nxt.dir_x    = ds[31:0];
    res_nxt.dir_y    = y01_r;
    res_nxt.dir_z    = cfg.viewer_distance;
    if (zdiv1_r) begin
      res_nxt.status = prg_pkg::ST_ZDIV;
    end else if (sat1_r || ds[32]) begin
      res_nxt.status = prg_pkg::ST_SAT;
    end else begin
      res_nxt.status = prg_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r    <= x1_nxt;
      x01_r   <= in_side.x0;
      y01_r   <= in_side.y0;
      sat1_r  <= sat1_nxt;
      zdiv1_r <= in_side.zdiv & active;
      res_r   <= res_nxt;
    end
  end

  assign out_vld = v2_r;
  assign out_res = res_r;

endmodule

>>> hdl/projector_ray_generator_core.sv
// one ray per cycle unless stalled; 7 front stages, 32 square-root stages,
// 2 multiply stages, 64 divider stages and 2 output stages, then a 2-entry output buffer
// the whole pipeline stalls only while the output buffer holds two results
// reset (synchronous, rst_n low) clears all valid bits and the buffer and loads the
// register defaults: half sizes and viewer distance 1.0, projector at origin, linear mode
module projector_ray_generator_core (
  input  logic                               clk,
  input  logic                               rst_n,
  prg_in_if.sink                             in_chan,
  prg_out_if.source                          out_chan,
  input  logic                               cfg_we,
  input  logic [prg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                        cfg_wdata
);

  prg_pkg::cfg_t cfg_r;

  logic en;
  logic fr_vld, sq_vld, div_vld, bk_vld;
  prg_pkg::side_t fr_side, sq_side, div_side;
  logic [63:0] fr_sa, fr_sb, quot;
  logic [31:0] s1, s2;
  prg_pkg::res_t bk_res;

  logic linear;
  logic signed [32:0] mop;
  logic signed [64:0] prod_nxt, prod_r;
  logic [31:0] den_nxt, den_r;
  logic [31:0] den2_r;
  logic negd_r, m1_vld_r, m2_vld_r;
  prg_pkg::side_t m1_side_nxt, m1_side_r, m2_side_nxt, m2_side_r;
  logic [63:0] num_nxt, num_r;

  prg_pkg::res_t ent_r [2];
  logic wptr_r, rptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic push, pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_width      <= 31'd65536;
      cfg_r.half_height     <= 31'd65536;
      cfg_r.viewer_distance <= 32'sd65536;
      cfg_r.proj_pos_x      <= '0;
      cfg_r.proj_pos_y      <= '0;
      cfg_r.proj_pos_z      <= '0;
      cfg_r.diffuser_mode   <= prg_pkg::MODE_LINEAR;
    end else if (cfg_we) begin
      case (cfg_index)
        prg_pkg::CFG_HALF_WIDTH:  cfg_r.half_width      <= cfg_wdata[30:0];
        prg_pkg::CFG_HALF_HEIGHT: cfg_r.half_height     <= cfg_wdata[30:0];
        prg_pkg::CFG_VIEWER_DIST: cfg_r.viewer_distance <= cfg_wdata;
        prg_pkg::CFG_PROJ_POS_X:  cfg_r.proj_pos_x      <= cfg_wdata;
        prg_pkg::CFG_PROJ_POS_Y:  cfg_r.proj_pos_y      <= cfg_wdata;
        prg_pkg::CFG_PROJ_POS_Z:  cfg_r.proj_pos_z      <= cfg_wdata;
        prg_pkg::CFG_DIFF_MODE:   cfg_r.diffuser_mode   <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  assign en = (cnt_r != 2'd2);
  assign in_chan.ready = en;

  prg_front u_front (
    .clk(clk), .rst_n(rst_n), .en(en), .cfg(cfg_r),
    .in_vld(in_chan.valid), .px(in_chan.pixel_x), .py(in_chan.pixel_y),
    .out_vld(fr_vld), .out_side(fr_side), .sum_a(fr_sa), .sum_b(fr_sb)
  );

  prg_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(fr_vld), .in_side(fr_side), .in_a(fr_sa), .in_b(fr_sb),
    .out_vld(sq_vld), .out_side(sq_side), .root_a(s1), .root_b(s2)
  );

  // dividend and divisor for the selected diffuser
  assign linear   = (cfg_r.diffuser_mode == prg_pkg::MODE_LINEAR);
  assign mop      = linear ? 33'(cfg_r.viewer_distance) : $signed({1'b0, s2});
  assign prod_nxt = 65'(mop) * 65'(sq_side.dx);
  assign den_nxt  = linear ? (sq_side.dz[31] ? 32'(-sq_side.dz) : sq_side.dz) : s1;

  always_comb begin
    m1_side_nxt      = sq_side;
    m1_side_nxt.zdiv = (den_nxt == 32'd0);
  end

  assign num_nxt = prod_r[64] ? 64'(-prod_r) : prod_r[63:0];

  always_comb begin
    m2_side_nxt     = m1_side_r;
    m2_side_nxt.neg = prod_r[64] ^ negd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
      m2_vld_r <= 1'b0;
    end else if (en) begin
      m1_vld_r <= sq_vld;
      m2_vld_r <= m1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r    <= prod_nxt;
      den_r     <= den_nxt;
      negd_r    <= linear & sq_side.dz[31];
      m1_side_r <= m1_side_nxt;
      num_r     <= num_nxt;
      m2_side_r <= m2_side_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den2_r <= den_r;
    end
  end

  prg_div u_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(m2_vld_r), .in_side(m2_side_r), .in_num(num_r), .in_den(den2_r),
    .out_vld(div_vld), .out_side(div_side), .quot(quot)
  );

  prg_back u_back (
    .clk(clk), .rst_n(rst_n), .en(en), .cfg(cfg_r),
    .in_vld(div_vld), .in_side(div_side), .quot(quot),
    .out_vld(bk_vld), .out_res(bk_res)
  );

  // two-entry output buffer
  assign push = en && bk_vld;
  assign pop  = out_chan.valid && out_chan.ready;
  assign cnt_nxt = cnt_r + 2'(push) - 2'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 2'd0;
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (pop) begin
        rptr_r <= ~rptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wptr_r] <= bk_res;
    end
  end

  assign out_chan.valid    = (cnt_r != 2'd0);
  assign out_chan.origin_x = ent_r[rptr_r].origin_x;
  assign out_chan.dir_x    = ent_r[rptr_r].dir_x;
  assign out_chan.dir_y    = ent_r[rptr_r].dir_y;
  assign out_chan.dir_z    = ent_r[rptr_r].dir_z;
  assign out_chan.status   = ent_r[rptr_r].status;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("output buffer count out of range");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> cnt_r == 2'd2)
    else $error("input stalled with buffer room");

  a_zdiv_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.status == prg_pkg::ST_ZDIV |-> out_chan.dir_x == 32'sd0)
    else $error("zero divisor result with nonzero dir_x");

  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd0 && !push |=> cnt_r == 2'd0)
    else $error("buffer filled without a push");

endmodule
